// ===== sv/rmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and types of the running median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int SAMPLE_BITS = 24;
  localparam int RADIUS_BITS = 4;

  // per-cell control, one copy for every cell of the sorted row
  typedef struct packed {
    logic upd;          // cell takes its next value on this edge
    logic above;        // the vacated slot lies above this cell
    logic at_or_above;  // the vacated slot is this cell or above it
    logic cur_ok;       // the remaining entry at this position exists
    logic has_prev;     // a lower neighbor exists
    logic dec;          // age tags count down (window is full)
  } cell_ctrl_t;

endpackage

// ===== sv/rmf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_in_if
// Sample stream into the median filter: valid, ready and one sample.
// ----------------------------------------------------------------------------
interface rmf_in_if #(
  parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          line_start;

  modport source (output valid, output sample, output line_start, input ready);
  modport sink   (input valid, input sample, input line_start, output ready);
endinterface

// ===== sv/rmf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_out_if
// Median stream out of the filter: valid, ready and one median.
// ----------------------------------------------------------------------------
interface rmf_out_if #(
  parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median;
  logic                          first_of_line;

  modport source (output valid, output median, output first_of_line, input ready);
  modport sink   (input valid, input median, input first_of_line, output ready);
endinterface

// ===== sv/running_median_filter_1d.sv =====
`timescale 1ns / 1ps
// The transfer of the sample that completes or updates the window updates the
// cells and marks a result pending, which then moves to the output register.
// Throughput: one sample per cycle while no result waits for a full output;
// all slots of the sorted row compare, shift and insert together. The first
// 2R samples of a line give no median. Reset clears the fill count and the
// result stages and sets radius to 1; window slots are not cleared.
// ----------------------------------------------------------------------------
// running_median_filter_1d
// Sliding-window running median along one image line, kept as a sorted row
// of cells with age tags; the oldest entry is replaced by each new sample.
// ----------------------------------------------------------------------------
module running_median_filter_1d #(
  parameter int MAX_RADIUS  = rmf_pkg::MAX_RADIUS,
  parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rmf_pkg::RADIUS_BITS-1:0] cfg_wr_data,
  rmf_in_if.sink                          din,
  rmf_out_if.source                       dout
);

  localparam int N  = 2 * MAX_RADIUS + 1;
  localparam int CW = $clog2(N + 1);
  localparam int IW = $clog2(N);
  localparam int AW = $clog2(N);
  localparam int EW = ((CW > rmf_pkg::RADIUS_BITS) ? CW : rmf_pkg::RADIUS_BITS) + 1;

  logic [rmf_pkg::RADIUS_BITS-1:0] radius;
  logic [CW-1:0]                   fill;
  logic                            pend;
  logic                            pend_first;

  logic [EW-1:0]                   rad_ext;
  logic [EW-1:0]                   reff_ext;
  logic [CW-1:0]                   win;
  logic [IW-1:0]                   med_idx;
  logic [CW-1:0]                   fill_eff;
  logic                            fill_mode;
  logic [CW-1:0]                   len;
  logic [CW-1:0]                   fill_next;
  logic                            emit;
  logic                            accept;
  logic                            out_free;
  logic [N-1:0]                    gap;

  rmf_pkg::cell_ctrl_t             ctrl [N];
  logic signed [SAMPLE_BITS-1:0]   cell_value [N];
  logic [AW-1:0]                   cell_age [N];
  logic [N-1:0]                    cell_le;
  logic signed [SAMPLE_BITS-1:0]   med_value;

  // effective radius, window length and median slot
  always_comb begin
    rad_ext = EW'(radius);
    if (rad_ext == '0) begin
      reff_ext = EW'(1);
    end else if (rad_ext > EW'(MAX_RADIUS)) begin
      reff_ext = EW'(MAX_RADIUS);
    end else begin
      reff_ext = rad_ext;
    end
    win     = CW'({reff_ext, 1'b1});
    med_idx = IW'(reff_ext);
  end

  // fill tracking: the window restarts on a line start
  always_comb begin
    fill_eff  = (din.line_start || (fill > win)) ? '0 : fill;
    fill_mode = (fill_eff < win);
    len       = fill_mode ? fill_eff : (win - CW'(1));
    fill_next = fill_mode ? (fill_eff + CW'(1)) : fill_eff;
    emit      = !fill_mode || (fill_next == win);
  end

  // handshake: input stalls only while a result waits for a full output
  assign out_free  = !dout.valid || dout.ready;
  assign din.ready = !pend || out_free;
  assign accept    = din.valid && din.ready;

  // slot that is vacated: next free slot while filling, the oldest entry after
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (fill_mode) begin
        gap[i] = (fill_eff == CW'(i));
      end else begin
        gap[i] = (cell_age[i] == '0) && (CW'(i) < win);
      end
    end
  end

  // per-cell control
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctrl[i].upd         = accept && (CW'(i) <= len);
      ctrl[i].above       = |(gap >> (i + 1));
      ctrl[i].at_or_above = |(gap >> i);
      ctrl[i].cur_ok      = (CW'(i) < len);
      ctrl[i].has_prev    = (i > 0);
      ctrl[i].dec         = !fill_mode;
    end
  end

  // sorted row of cells, each wired to both neighbors
  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int P = (g == 0) ? 0 : g - 1;
    localparam int Q = (g == N - 1) ? g : g + 1;

    rmf_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (AW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .sample    (din.sample),
      .new_age   (AW'(len)),
      .prv_value (cell_value[P]),
      .prv_age   (cell_age[P]),
      .prv_le    (cell_le[P]),
      .nxt_value (cell_value[Q]),
      .nxt_age   (cell_age[Q]),
      .nxt_le    (cell_le[Q]),
      .value     (cell_value[g]),
      .age       (cell_age[g]),
      .le        (cell_le[g])
    );
  end

  assign med_value = cell_value[med_idx];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= rmf_pkg::RADIUS_BITS'(1);
      fill       <= '0;
      pend       <= 1'b0;
      pend_first <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radius <= cfg_wr_data;
        fill   <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (accept) begin
        pend       <= emit;
        pend_first <= fill_mode;
      end else if (out_free) begin
        pend <= 1'b0;
      end
      if (out_free) begin
        dout.valid <= pend;
      end
    end
  end

  // output payload, loaded as the pending result moves out
  always_ff @(posedge clk) begin
    if (pend && out_free) begin
      dout.median        <= med_value;
      dout.first_of_line <= pend_first;
    end
  end

`ifndef NO_ASSERTIONS
  // a full window has exactly one oldest entry
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    (din.valid && !fill_mode) |-> $onehot(gap))
    else $error("full window without a single oldest entry");

  // the fill count never runs past the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= win)
    else $error("fill count beyond window length");

  // a transfer that completes the window leaves a result pending
  a_emit_pend: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> pend)
    else $error("result lost after window update");

  // a radius write empties the window
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (fill == '0))
    else $error("radius write did not clear the window");
`endif

endmodule

// ===== sv/rmf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_cell
// One slot of the sorted window: holds a value and its age tag, and on each
// update takes its own value, a neighbor's value or the new sample.
// ----------------------------------------------------------------------------
module rmf_cell #(
  parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS,
  parameter int AGE_BITS    = 5
) (
  input  logic                          clk,
  input  rmf_pkg::cell_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [AGE_BITS-1:0]           new_age,
  input  logic signed [SAMPLE_BITS-1:0] prv_value,
  input  logic [AGE_BITS-1:0]           prv_age,
  input  logic                          prv_le,
  input  logic signed [SAMPLE_BITS-1:0] nxt_value,
  input  logic [AGE_BITS-1:0]           nxt_age,
  input  logic                          nxt_le,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [AGE_BITS-1:0]           age,
  output logic                          le
);

  logic signed [SAMPLE_BITS-1:0] cur_value;
  logic [AGE_BITS-1:0]           cur_age;
  logic                          cur_le;
  logic signed [SAMPLE_BITS-1:0] low_value;
  logic [AGE_BITS-1:0]           low_age;
  logic                          low_le;
  logic signed [SAMPLE_BITS-1:0] value_next;
  logic [AGE_BITS-1:0]           age_next;
  logic [AGE_BITS-1:0]           age_dec;

  // order of the held value against the incoming sample
  assign le = (value <= sample);

  assign age_dec = AGE_BITS'(ctrl.dec);

  // remaining entries at this position and one below, with the vacated slot closed
  always_comb begin
    cur_value = ctrl.above ? value : nxt_value;
    cur_age   = ctrl.above ? age   : nxt_age;
    cur_le    = ctrl.above ? le    : nxt_le;
    low_value = ctrl.at_or_above ? prv_value : value;
    low_age   = ctrl.at_or_above ? prv_age   : age;
    low_le    = ctrl.at_or_above ? prv_le    : le;
  end

  // entries not above the sample stay below it, larger ones move up past it
  always_comb begin
    if (ctrl.cur_ok && cur_le) begin
      value_next = cur_value;
      age_next   = cur_age - age_dec;
    end else if (ctrl.has_prev && !low_le) begin
      value_next = low_value;
      age_next   = low_age - age_dec;
    end else begin
      value_next = sample;
      age_next   = new_age;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// ===== tb/sv/running_median_filter_1d_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_filter_1d_tb
// Self-checking bench for the sliding-window median filter. A short table of
// directed samples and radius writes comes first, then random image lines at
// several radii. A bit-accurate window model in the bench predicts every
// median not typed in the table; three modes set how often each side idles.
// ----------------------------------------------------------------------------
module running_median_filter_1d_tb;

  localparam int MAX_RADIUS  = rmf_pkg::MAX_RADIUS;
  localparam int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS;
  localparam int RADIUS_BITS = rmf_pkg::RADIUS_BITS;

  localparam int DEPTH       = 2 * MAX_RADIUS + 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_GAP  = 6;
  localparam int HALF_ITEMS  = 64;

  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t median;
    logic    first_of_line;
  } median_res_t;

  typedef struct packed {
    sample_t     sample;
    logic        line_start;
    logic        known;
    median_res_t typed;
  } pending_sample_t;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_RADIUS} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [RADIUS_BITS-1:0]  radius;
    sample_t                 sample;
    logic                    line_start;
    logic                    known;
    sample_t                 median;
    logic                    first_of_line;
  } stim_row_t;

  // directed rows: expected medians typed in where they are obvious
  localparam stim_row_t DIR_ROWS [25] = '{
    '{ROW_SAMPLE, 4'd0,  SMIN,     1'b0, 1'b0, 24'sd0,  1'b0}, // fill without line start
    '{ROW_SAMPLE, 4'd0,  SMAX,     1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd0,   1'b0, 1'b1, 24'sd0,  1'b1},
    '{ROW_SAMPLE, 4'd0,  SMAX,     1'b0, 1'b1, SMAX,    1'b0},
    '{ROW_SAMPLE, 4'd0,  -24'sd1,  1'b0, 1'b1, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd5,   1'b1, 1'b0, 24'sd0,  1'b0}, // new line, equal values
    '{ROW_SAMPLE, 4'd0,  24'sd5,   1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd5,   1'b0, 1'b1, 24'sd5,  1'b1},
    '{ROW_SAMPLE, 4'd0,  24'sd7,   1'b0, 1'b1, 24'sd5,  1'b0},
    '{ROW_RADIUS, 4'd0,  24'sd0,   1'b0, 1'b0, 24'sd0,  1'b0}, // zero radius acts as one
    '{ROW_SAMPLE, 4'd0,  24'sd3,   1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd1,   1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd2,   1'b0, 1'b1, 24'sd2,  1'b1},
    '{ROW_RADIUS, 4'd2,  24'sd0,   1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd100, 1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd200, 1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_RADIUS, 4'd2,  24'sd0,   1'b0, 1'b0, 24'sd0,  1'b0}, // rewrite drops partial fill
    '{ROW_SAMPLE, 4'd0,  -24'sd2,  1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd2,   1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd0,   1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  -24'sd1,  1'b0, 1'b0, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd1,   1'b0, 1'b1, 24'sd0,  1'b1},
    '{ROW_SAMPLE, 4'd0,  SMIN,     1'b0, 1'b1, 24'sd0,  1'b0},
    '{ROW_SAMPLE, 4'd0,  24'sd9,   1'b1, 1'b0, 24'sd0,  1'b0}, // restart a full window
    '{ROW_SAMPLE, 4'd0,  SMAX,     1'b0, 1'b0, 24'sd0,  1'b0}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [RADIUS_BITS-1:0] cfg_wr_data;

  rmf_in_if  din_if ();
  rmf_out_if dout_if ();

  running_median_filter_1d dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .din         (din_if),
    .dout        (dout_if)
  );

  // window model state
  sample_t                win_val [DEPTH];
  logic [4:0]             win_age [DEPTH];
  int                     win_fill;
  logic [RADIUS_BITS-1:0] radius_reg;

  pending_sample_t pending_samples [$];
  median_res_t     expected_medians [$];

  int src_idle_pct;
  int snk_idle_pct;
  int mismatch_count;
  int cycle_count;
  int line_left;

  always #4 clk = ~clk;

  function automatic void swap_entries(int a, int b);
    sample_t    tv;
    logic [4:0] ta;
    tv = win_val[a];
    ta = win_age[a];
    win_val[a] = win_val[b];
    win_age[a] = win_age[b];
    win_val[b] = tv;
    win_age[b] = ta;
  endfunction

  // move entry k toward its neighbors until the first n entries are sorted
  function automatic void resettle_entry(int k, int n);
    while (k > 0 && win_val[k] < win_val[k-1]) begin
      swap_entries(k, k - 1);
      k--;
    end
    while (k + 1 < n && win_val[k] > win_val[k+1]) begin
      swap_entries(k, k + 1);
      k++;
    end
  endfunction

  // apply one accepted sample to the window and queue the median it yields
  function automatic void advance_window(pending_sample_t it);
    int          r;
    int          w;
    int          k;
    logic        got;
    median_res_t res;
    r   = (radius_reg == '0) ? 1 : int'(radius_reg);
    w   = 2 * r + 1;
    got = 1'b0;
    res = '0;
    if (it.line_start) win_fill = 0;
    if (win_fill > w) win_fill = 0;
    if (win_fill < w) begin
      k = win_fill;
      win_val[k] = it.sample;
      win_age[k] = 5'(k);
      win_fill++;
      resettle_entry(k, win_fill);
      if (win_fill == w) begin
        got = 1'b1;
        res.first_of_line = 1'b1;
      end
    end else begin
      k = 0;
      for (int i = 0; i < w; i++) begin
        if (win_age[i] == '0) k = i;
        else win_age[i] = win_age[i] - 5'd1;
      end
      win_val[k] = it.sample;
      win_age[k] = 5'(w - 1);
      resettle_entry(k, w);
      got = 1'b1;
      res.first_of_line = 1'b0;
    end
    res.median = win_val[r];
    if (it.known) expected_medians.push_back(it.typed);
    else if (got) expected_medians.push_back(res);
  endfunction

  // sample source: valid holds until the transfer, gaps only between samples
  always @(posedge clk) begin
    if (rst) begin
      din_if.valid <= 1'b0;
    end else begin
      if (din_if.valid && din_if.ready) advance_window(pending_samples.pop_front());
      if (din_if.valid && !din_if.ready) begin
        din_if.valid <= 1'b1;
      end else if (pending_samples.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        din_if.valid      <= 1'b1;
        din_if.sample     <= pending_samples[0].sample;
        din_if.line_start <= pending_samples[0].line_start;
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  // median sink: random stalls, each transfer checked against the oldest expectation
  always @(posedge clk) begin
    median_res_t want;
    dout_if.ready <= !rst && ($urandom_range(0, 99) >= snk_idle_pct);
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (expected_medians.size() == 0) begin
        $error("unexpected median transfer: median %0d first_of_line %0b",
               dout_if.median, dout_if.first_of_line);
        mismatch_count++;
      end else begin
        want = expected_medians.pop_front();
        if (dout_if.median !== want.median) begin
          $error("median mismatch: expected %0d, actual %0d", want.median, dout_if.median);
          mismatch_count++;
        end
        if (dout_if.first_of_line !== want.first_of_line) begin
          $error("first_of_line mismatch: expected %0b, actual %0b",
                 want.first_of_line, dout_if.first_of_line);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || din_if.valid || expected_medians.size() != 0)
      @(negedge clk);
  endtask

  // radius write only once the filter is idle
  task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
    wait_drained();
    repeat (SETTLE_GAP) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    radius_reg  = r;
    win_fill    = 0;
    @(negedge clk);
  endtask

  // random image lines: mostly full lines, some short ones and stray restarts
  task automatic queue_random_lines(input int n);
    int              w;
    pending_sample_t it;
    w = 2 * ((radius_reg == '0) ? 1 : int'(radius_reg)) + 1;
    repeat (n) begin
      it = '0;
      if (line_left <= 0) begin
        it.line_start = 1'b1;
        line_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w) : $urandom_range(w, 4 * w);
      end else if ($urandom_range(0, 49) == 0) begin
        it.line_start = 1'b1;
      end
      line_left--;
      case ($urandom_range(0, 3))
        0:       it.sample = SAMPLE_BITS'($urandom);
        1:       it.sample = SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
        2:       it.sample = $urandom_range(0, 1) ? SMAX : SMIN;
        default: it.sample = SAMPLE_BITS'(int'($urandom_range(0, 2000)) - 1000);
      endcase
      pending_samples.push_back(it);
    end
  endtask

  initial begin
    pending_sample_t it;
    logic [RADIUS_BITS-1:0] r;
    clk               = 1'b0;
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    din_if.valid      = 1'b0;
    din_if.sample     = '0;
    din_if.line_start = 1'b0;
    dout_if.ready     = 1'b0;
    radius_reg        = 4'd1;
    win_fill          = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    line_left         = 0;
    src_idle_pct      = 10;
    snk_idle_pct      = 71;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_RADIUS) begin
        write_radius(DIR_ROWS[i].radius);
      end else begin
        it.sample                = DIR_ROWS[i].sample;
        it.line_start            = DIR_ROWS[i].line_start;
        it.known                 = DIR_ROWS[i].known;
        it.typed.median          = DIR_ROWS[i].median;
        it.typed.first_of_line   = DIR_ROWS[i].first_of_line;
        pending_samples.push_back(it);
      end
    end
    wait_drained();

    // random phases: three idle modes, several radii including the extremes
    for (int ph = 0; ph < 9; ph++) begin
      src_idle_pct = (ph < 3) ? 10 : (ph < 6) ? 71 : 0;
      snk_idle_pct = (ph < 3) ? 71 : (ph < 6) ? 10 : 0;
      case (ph)
        0, 4, 7: r = 4'd15;
        1, 6:    r = 4'd1;
        3:       r = 4'd0;
        default: r = RADIUS_BITS'($urandom_range(2, 14));
      endcase
      write_radius(r);
      queue_random_lines(HALF_ITEMS);
      // hold the source mid-line until every median is out
      wait_drained();
      queue_random_lines(HALF_ITEMS);
    end

    wait_drained();
    repeat (SETTLE_GAP) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
